/* hw/rtl/aoc_pkg.sv */
// Shared types and constants of the alpha-over compositor pipeline.
package aoc_pkg;

    // Field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned PROD_W   = 2 * CHAN_W;
    localparam int unsigned WGT_W    = 2 * CHAN_W;
    localparam int unsigned NUM_W    = 3 * CHAN_W;

    // Quotient bits resolved per divider stage, and the stage count that follows
    localparam int unsigned QBITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES      = CHAN_W / QBITS_PER_STAGE;

    // Full-scale channel value
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef logic [CHAN_W-1:0] chan_t;

    // Input pixel pair; colour index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [NUM_CH-1:0][CHAN_W-1:0] front_col;
        logic [NUM_CH-1:0][CHAN_W-1:0] back_col;
        chan_t                         front_alpha;
        chan_t                         back_alpha;
    } aoc_pair_t;

    // First product stage
    typedef struct packed {
        logic [NUM_CH-1:0][PROD_W-1:0] front_prod;
        logic [NUM_CH-1:0][PROD_W-1:0] back_prod;
        logic [PROD_W-1:0]             back_wgt;
        chan_t                         front_alpha;
        chan_t                         front_inv;
        logic                          clear;
    } aoc_prod_t;

    // Divider stage payload
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0]  rem;
        logic [NUM_CH-1:0][CHAN_W-1:0] quo;
        logic [WGT_W-1:0]              weight;
        chan_t                         alpha;
        logic                          clear;
    } aoc_div_t;

endpackage

/* hw/rtl/aoc_weight.sv */
// Two product stages: channel products, combined weight, numerators and output alpha.
module aoc_weight (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aoc_pkg::aoc_pair_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aoc_pkg::aoc_div_t out_data
);
    import aoc_pkg::*;

    logic      prod_valid_reg;
    aoc_prod_t prod_reg;
    aoc_prod_t prod_next;
    logic      div_valid_reg;
    aoc_div_t  div_reg;
    aoc_div_t  div_next;
    logic      prod_ready;
    logic      div_ready;

    // Stage ready: a stage takes a transfer when empty or draining
    assign div_ready  = !div_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || div_ready;
    assign in_ready   = prod_ready;
    assign out_valid  = div_valid_reg;
    assign out_data   = div_reg;

    // Form colour times alpha products and the back weight term
    always_comb
    begin
        chan_t inv;
        inv = CHAN_MAX - in_data.front_alpha;
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod_next.front_prod[c] = PROD_W'(in_data.front_col[c]) *
                                      PROD_W'(in_data.front_alpha);
            prod_next.back_prod[c]  = PROD_W'(in_data.back_col[c]) *
                                      PROD_W'(in_data.back_alpha);
        end
        prod_next.back_wgt    = PROD_W'(in_data.back_alpha) * PROD_W'(inv);
        prod_next.front_alpha = in_data.front_alpha;
        prod_next.front_inv   = inv;
        prod_next.clear       = (in_data.front_alpha == '0) && (in_data.back_alpha == '0);
    end

    // Weight, numerators and alpha = floor(W / 255) via (W + 1) * 257 >> 16
    always_comb
    begin
        logic [WGT_W-1:0]   wgt;
        logic [WGT_W:0]     wgt_inc;
        logic [WGT_W+8:0]   alpha_prod;
        logic [NUM_W-1:0]   front_term;
        logic [NUM_W-1:0]   back_term;
        wgt = ({prod_reg.front_alpha, 8'b0} - WGT_W'(prod_reg.front_alpha)) +
              prod_reg.back_wgt;
        wgt_inc    = {1'b0, wgt} + 17'd1;
        alpha_prod = {wgt_inc, 8'b0} + 25'(wgt_inc);
        for (int c = 0; c < NUM_CH; c++)
        begin
            front_term = {prod_reg.front_prod[c], 8'b0} - NUM_W'(prod_reg.front_prod[c]);
            back_term  = NUM_W'(prod_reg.back_prod[c]) * NUM_W'(prod_reg.front_inv);
            div_next.rem[c] = front_term + back_term;
            div_next.quo[c] = '0;
        end
        div_next.weight = wgt;
        div_next.alpha  = alpha_prod[23:16];
        div_next.clear  = prod_reg.clear;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (div_ready)
            begin
                div_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Load payload on transfer
    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (div_ready && prod_valid_reg)
        begin
            div_reg <= div_next;
        end
    end

endmodule

/* hw/rtl/aoc_div_step.sv */
// One restoring-divider stage: resolves a few quotient bits for all three colours.
module aoc_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aoc_pkg::aoc_div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output aoc_pkg::aoc_div_t out_data
);
    import aoc_pkg::*;

    logic     valid_reg;
    aoc_div_t data_reg;
    aoc_div_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift remainder, compare against weight << 8, subtract when it fits
    always_comb
    begin
        logic [NUM_W-1:0]  dvs;
        logic [NUM_W-1:0]  r;
        logic [CHAN_W-1:0] q;
        logic [NUM_W:0]    trial;
        dvs       = {in_data.weight, 8'b0};
        data_next = in_data;
        for (int c = 0; c < NUM_CH; c++)
        begin
            r = in_data.rem[c];
            q = in_data.quo[c];
            for (int k = 0; k < QBITS_PER_STAGE; k++)
            begin
                trial = {r, 1'b0};
                if (trial >= {1'b0, dvs})
                begin
                    trial = trial - {1'b0, dvs};
                    q     = {q[CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[CHAN_W-2:0], 1'b0};
                end
                r = trial[NUM_W-1:0];
            end
            data_next.rem[c] = r;
            data_next.quo[c] = q;
        end
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on transfer
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* hw/rtl/alpha_over_compositor_core.sv */
// Top level of the alpha-over compositor: straight-alpha RGBA8 Porter-Duff over.
//
// Usage: each transfer on the slave channel carries one front and one back
// RGBA8 pixel; each transfer on the master channel carries the composited pixel.
// Colours are the exact truncated quotient of the weighted sum by the combined
// weight W = 255*fa + ba*(255-fa); alpha is W / 255 truncated. When both alphas
// are zero the colour and alpha fields are zero and tuser is set.
//
// Pipeline: two product stages, then four divider stages, each resolving two
// quotient bits for all colours.
// Throughput: one pixel per clock unless the receiver stalls; the divider is
// fully pipelined, so the quotient bits per stage set the depth, not the rate.
//
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls, each stage holds its item and empty stages ahead
// of a stalled one keep taking new transfers until the pipeline is full.
module alpha_over_compositor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // front_red, front_green, front_blue, front_alpha,
    // back_red, back_green, back_blue, back_alpha
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0] m_tdata,
    // both_transparent
    output logic        m_tuser
);
    import aoc_pkg::*;

    aoc_pair_t pair;
    logic      stg_valid [DIV_STAGES+1];
    logic      stg_ready [DIV_STAGES+1];
    aoc_div_t  stg_data  [DIV_STAGES+1];

    // Unpack input fields
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            pair.front_col[c] = s_tdata[c*CHAN_W +: CHAN_W];
            pair.back_col[c]  = s_tdata[(c+4)*CHAN_W +: CHAN_W];
        end
        pair.front_alpha = s_tdata[31:24];
        pair.back_alpha  = s_tdata[63:56];
    end

    aoc_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pair),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Divider chain
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        aoc_div_step u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    assign stg_ready[DIV_STAGES] = m_tready;
    assign m_tvalid              = stg_valid[DIV_STAGES];

    // Pack result; force colours and alpha to zero when both pixels are transparent
    always_comb
    begin
        aoc_div_t res;
        res = stg_data[DIV_STAGES];
        for (int c = 0; c < NUM_CH; c++)
        begin
            m_tdata[c*CHAN_W +: CHAN_W] = res.clear ? '0 : res.quo[c];
        end
        m_tdata[31:24] = res.clear ? '0 : res.alpha;
        m_tuser        = res.clear;
    end

endmodule

/* bench/over_blend_checker.sv */
// Checker for the alpha-over compositor: predicts each blended pixel and compares results.
module over_blend_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import aoc_pkg::*;

    // One composited pixel, laid out as {tuser, tdata}
    typedef struct packed {
        logic  both_transparent;
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } blended_pixel_t;

    blended_pixel_t expected_pixels[$];
    int             error_count = 0;

    // Porter-Duff over on straight alpha, exact integer quotients
    function automatic blended_pixel_t blend_over(logic [63:0] pair);
        int unsigned    fa;
        int unsigned    ba;
        int unsigned    inv_fa;
        int unsigned    weight;
        int unsigned    numer;
        chan_t          col[3];
        blended_pixel_t res;
        fa     = pair[31:24];
        ba     = pair[63:56];
        inv_fa = int'(CHAN_MAX) - fa;
        weight = int'(CHAN_MAX) * fa + ba * inv_fa;
        // Both pixels fully transparent: force zeros and raise the flag
        if (weight == 0) begin
            res = '0;
            res.both_transparent = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            numer  = int'(pair[8*i +: 8]) * fa * int'(CHAN_MAX)
                   + int'(pair[32 + 8*i +: 8]) * ba * inv_fa;
            col[i] = chan_t'(numer / weight);
        end
        res.red              = col[0];
        res.green            = col[1];
        res.blue             = col[2];
        res.alpha            = chan_t'(weight / int'(CHAN_MAX));
        res.both_transparent = 1'b0;
        return res;
    endfunction

    // Queue a prediction per input transfer, check each output transfer
    always @(posedge clk) begin
        blended_pixel_t got;
        blended_pixel_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                expected_pixels.push_back(blend_over(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (expected_pixels.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d flag=%0d",
                                 $realtime, got.red, got.green, got.blue, got.alpha,
                                 got.both_transparent);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red != want.red || got.green != want.green ||
                        got.blue != want.blue || got.alpha != want.alpha ||
                        got.both_transparent != want.both_transparent) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d a=%0d flag=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     want.alpha, want.both_transparent);
                            $display("    got r=%0d g=%0d b=%0d a=%0d flag=%0d",
                                     got.red, got.green, got.blue, got.alpha,
                                     got.both_transparent);
                        end
                    end
                end
            end
        end
        mismatches <= error_count;
        pending    <= expected_pixels.size();
    end

endmodule

/* bench/alpha_over_compositor_core_test.sv */
// Testbench top for the alpha-over compositor: drives pixel pairs and reports the verdict.
module alpha_over_compositor_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import aoc_pkg::*;

    localparam int RANDOM_PER_PHASE = 534;
    localparam int DRAIN_CYCLES     = 24;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    alpha_over_compositor_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    over_blend_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the output side at the current rate
    initial begin
        forever begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Bound the run well past the slowest legal completion
    initial begin
        #2_400_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] pixel_pair(chan_t fr, chan_t fg, chan_t fb, chan_t fa,
                                               chan_t br, chan_t bg, chan_t bb, chan_t ba);
        return {ba, bb, bg, br, fa, fb, fg, fr};
    endfunction

    // Pick an alpha at or next to an end of the range
    function automatic chan_t edge_alpha();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return CHAN_MAX - 8'd1;
            default: return CHAN_MAX;
        endcase
    endfunction

    // Present one pair, with random idle cycles ahead, and hold it until the transfer
    task automatic send_pair(logic [63:0] pair);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_pair();
        logic [63:0] pair;
        pair = {$urandom, $urandom};
        case ($urandom_range(9))
            0: begin
                pair[31:24] = '0;
                pair[63:56] = '0;
            end
            1, 2, 3: begin
                pair[31:24] = edge_alpha();
                pair[63:56] = edge_alpha();
            end
            default: ;
        endcase
        send_pair(pair);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: sender idles lightly, receiver heavily
        send_idle_pct = 17;
        recv_idle_pct = 55;

        // Directed corners: transparency, opacity, and extreme colours
        send_pair(pixel_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pixel_pair(255, 255, 255, 0, 255, 255, 255, 0));
        send_pair(pixel_pair(10, 200, 255, 255, 90, 0, 33, 0));
        send_pair(pixel_pair(10, 200, 255, 0, 90, 0, 33, 255));
        send_pair(pixel_pair(255, 255, 255, 255, 255, 255, 255, 255));
        send_pair(pixel_pair(255, 0, 128, 1, 0, 255, 127, 0));
        send_pair(pixel_pair(255, 0, 128, 0, 0, 255, 127, 1));
        send_pair(pixel_pair(255, 0, 128, 1, 0, 255, 127, 1));
        send_pair(pixel_pair(1, 2, 3, 254, 252, 253, 254, 255));
        send_pair(pixel_pair(12, 34, 56, 255, 78, 90, 123, 255));
        send_pair(pixel_pair(200, 100, 50, 128, 50, 100, 200, 128));
        send_pair(64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(pixel_pair(255, 255, 255, 1, 0, 0, 0, 255));
        send_pair(pixel_pair(0, 0, 0, 254, 255, 255, 255, 1));
        send_pair(64'hAAAA_AAAA_AAAA_AAAA);
        send_pair(64'h5555_5555_5555_5555);
        send_pair(pixel_pair(0, 0, 0, 0, 255, 255, 255, 255));
        send_pair(pixel_pair(255, 255, 255, 255, 0, 0, 0, 0));
        repeat (RANDOM_PER_PHASE) send_random_pair();

        // Phase two: the other way round
        send_idle_pct = 55;
        recv_idle_pct = 17;
        repeat (RANDOM_PER_PHASE) send_random_pair();

        // Phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_pair();
        s_tvalid <= 1'b0;

        // Drain the pipeline, then keep watching for stray results
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/aoc_pkg.sv
hw/rtl/aoc_weight.sv
hw/rtl/aoc_div_step.sv
hw/rtl/alpha_over_compositor_core.sv
bench/over_blend_checker.sv
bench/alpha_over_compositor_core_test.sv
